### rtl/sma_pkg.sv
package sma_pkg;

	// port widths fixed by the interface
	localparam int PORT_BITS = 64;
	localparam int CMD_BITS  = 3;
	localparam int TAG_BITS  = 3;

	typedef logic [CMD_BITS-1:0] cmd_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic signed [1:0]   cmp_t;

	// commands
	localparam cmd_t CMD_ADD    = 3'd0;
	localparam cmd_t CMD_SUB    = 3'd1;
	localparam cmd_t CMD_NEG    = 3'd2;
	localparam cmd_t CMD_HALVE  = 3'd3;
	localparam cmd_t CMD_DOUBLE = 3'd4;
	localparam cmd_t CMD_CMP    = 3'd5;

	// status tags
	localparam tag_t TAG_POS     = 3'd0;
	localparam tag_t TAG_NEG     = 3'd1;
	localparam tag_t TAG_ERR     = 3'd2;
	localparam tag_t TAG_OVF_POS = 3'd3;
	localparam tag_t TAG_OVF_NEG = 3'd4;
	localparam tag_t TAG_UNF_POS = 3'd5;
	localparam tag_t TAG_UNF_NEG = 3'd6;

	// compare outcomes
	localparam cmp_t CMP_LT = 2'sb11;
	localparam cmp_t CMP_EQ = 2'sb00;
	localparam cmp_t CMP_GT = 2'sb01;

endpackage

### rtl/sign_magnitude_fixed_alu.sv
// Sign-magnitude fixed-point ALU with status tags.
// A request passes the input register and then the result register; its result shows with done high.
// Throughput: one request per cycle; busy is always low and the receiver cannot stall.
// The path is input register, one adder/comparator pass, result register.
// Reset (arst_n low, asynchronous) clears the request valid bits; no result is pending after it.
module sign_magnitude_fixed_alu #(
	parameter int WHOLE_BITS = 64,
	parameter int FRAC_BITS  = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  sma_pkg::cmd_t                     cmd,
	input  logic [sma_pkg::PORT_BITS-1:0]     a_whole,
	input  logic [sma_pkg::PORT_BITS-1:0]     a_frac,
	input  sma_pkg::tag_t                     a_tag,
	input  logic [sma_pkg::PORT_BITS-1:0]     b_whole,
	input  logic [sma_pkg::PORT_BITS-1:0]     b_frac,
	input  sma_pkg::tag_t                     b_tag,
	output logic                              done,
	output logic [sma_pkg::PORT_BITS-1:0]     r_whole,
	output logic [sma_pkg::PORT_BITS-1:0]     r_frac,
	output sma_pkg::tag_t                     r_tag,
	output sma_pkg::cmp_t                     cmp_result
);
	import sma_pkg::*;

	localparam int MAG_BITS = WHOLE_BITS + FRAC_BITS;

	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [MAG_BITS-1:0] a_mag_s1;
	tag_t                a_tag_s1;
	logic [MAG_BITS-1:0] b_mag_s1;
	tag_t                b_tag_s1;

	logic [MAG_BITS-1:0] core_mag;
	tag_t                core_tag;
	cmp_t                core_cmp;

	logic                valid_s2;
	logic [MAG_BITS-1:0] r_mag_s2;
	tag_t                r_tag_s2;
	cmp_t                r_cmp_s2;

	// no back-pressure: a request is taken every cycle start is high
	assign busy = 1'b0;

	// request valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	// input register, wide bits above the configured widths are dropped
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1   <= cmd;
			a_mag_s1 <= {a_whole[WHOLE_BITS-1:0], a_frac[FRAC_BITS-1:0]};
			a_tag_s1 <= a_tag;
			b_mag_s1 <= {b_whole[WHOLE_BITS-1:0], b_frac[FRAC_BITS-1:0]};
			b_tag_s1 <= b_tag;
		end
	end

	sma_core #(
		.WHOLE_BITS (WHOLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_core (
		.cmd   (cmd_s1),
		.a_mag (a_mag_s1),
		.a_tag (a_tag_s1),
		.b_mag (b_mag_s1),
		.b_tag (b_tag_s1),
		.r_mag (core_mag),
		.r_tag (core_tag),
		.r_cmp (core_cmp)
	);

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			r_mag_s2 <= core_mag;
			r_tag_s2 <= core_tag;
			r_cmp_s2 <= core_cmp;
		end
	end

	assign done       = valid_s2;
	assign r_whole    = PORT_BITS'(r_mag_s2[MAG_BITS-1:FRAC_BITS]);
	assign r_frac     = PORT_BITS'(r_mag_s2[FRAC_BITS-1:0]);
	assign r_tag      = r_tag_s2;
	assign cmp_result = r_cmp_s2;

	// every request yields a result with done high
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("request did not produce a result");

	// error results carry a zero magnitude and no compare outcome
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && r_tag == TAG_ERR) |-> (r_whole == '0 && r_frac == '0 && cmp_result == CMP_EQ))
		else $error("error result with nonzero payload");

	// a compare outcome only comes with a plain zero result
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmp_result != CMP_EQ) |-> (r_tag == TAG_POS && r_whole == '0 && r_frac == '0))
		else $error("compare outcome with arithmetic payload");

	// compare outcome is never the unused code
	a_cmp_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cmp_result != 2'sb10))
		else $error("invalid compare code");

endmodule

### rtl/sma_core.sv
module sma_core #(
	parameter int WHOLE_BITS = 64,
	parameter int FRAC_BITS  = 64
) (
	input  sma_pkg::cmd_t                      cmd,
	input  logic [WHOLE_BITS+FRAC_BITS-1:0]    a_mag,
	input  sma_pkg::tag_t                      a_tag,
	input  logic [WHOLE_BITS+FRAC_BITS-1:0]    b_mag,
	input  sma_pkg::tag_t                      b_tag,
	output logic [WHOLE_BITS+FRAC_BITS-1:0]    r_mag,
	output sma_pkg::tag_t                      r_tag,
	output sma_pkg::cmp_t                      r_cmp
);
	import sma_pkg::*;

	localparam int MAG_BITS = WHOLE_BITS + FRAC_BITS;

	logic                a_ok;
	logic                b_ok;
	logic                a_zero;
	logic                b_zero;
	tag_t                nb_tag;
	tag_t                y_tag;
	logic [MAG_BITS-1:0] y_mag;
	logic [MAG_BITS-1:0] p_mag;
	logic [MAG_BITS-1:0] n_mag;
	logic [MAG_BITS:0]   sum;
	logic [MAG_BITS:0]   d_pn;
	logic [MAG_BITS-1:0] d_np;
	logic [MAG_BITS-1:0] add_mag;
	tag_t                add_tag;
	cmp_t                mag_ord;
	cmp_t                cmp_v;

	// operand checks and negated second operand
	always_comb begin
		a_ok   = a_tag inside {TAG_POS, TAG_NEG};
		b_ok   = b_tag inside {TAG_POS, TAG_NEG};
		a_zero = (a_mag == '0);
		b_zero = (b_mag == '0);
		nb_tag = (!b_zero && b_tag == TAG_POS) ? TAG_NEG : TAG_POS;
	end

	// second addend: b, -b, or a itself for double
	always_comb begin
		case (cmd)
			CMD_SUB: begin
				y_mag = b_mag;
				y_tag = nb_tag;
			end
			CMD_DOUBLE: begin
				y_mag = a_mag;
				y_tag = a_tag;
			end
			default: begin
				y_mag = b_mag;
				y_tag = b_tag;
			end
		endcase
	end

	// signed-magnitude add: like signs add, unlike signs subtract larger minus smaller
	always_comb begin
		sum   = {1'b0, a_mag} + {1'b0, y_mag};
		p_mag = (a_tag == TAG_POS) ? a_mag : y_mag;
		n_mag = (a_tag == TAG_POS) ? y_mag : a_mag;
		d_pn  = {1'b0, p_mag} - {1'b0, n_mag};
		d_np  = n_mag - p_mag;
		if (a_tag == y_tag) begin
			add_mag = sum[MAG_BITS-1:0];
			if (sum[MAG_BITS])
				add_tag = (a_tag == TAG_POS) ? TAG_OVF_POS : TAG_OVF_NEG;
			else
				add_tag = a_tag;
		end else if (!d_pn[MAG_BITS]) begin
			add_mag = d_pn[MAG_BITS-1:0];
			add_tag = TAG_POS;
		end else begin
			add_mag = d_np;
			add_tag = TAG_NEG;
		end
	end

	// signed compare of a against b
	always_comb begin
		if (a_mag > b_mag)
			mag_ord = CMP_GT;
		else if (a_mag < b_mag)
			mag_ord = CMP_LT;
		else
			mag_ord = CMP_EQ;
		if (a_tag == b_tag) begin
			if (a_tag == TAG_POS)
				cmp_v = mag_ord;
			else if (mag_ord == CMP_GT)
				cmp_v = CMP_LT;
			else if (mag_ord == CMP_LT)
				cmp_v = CMP_GT;
			else
				cmp_v = CMP_EQ;
		end else begin
			cmp_v = (a_tag == TAG_POS) ? CMP_GT : CMP_LT;
		end
	end

	// result select, invalid operands and unknown commands give the error tag
	always_comb begin
		r_mag = '0;
		r_tag = TAG_POS;
		r_cmp = CMP_EQ;
		case (cmd)
			CMD_ADD, CMD_SUB: begin
				if (a_ok && b_ok) begin
					r_mag = add_mag;
					r_tag = add_tag;
				end else begin
					r_tag = TAG_ERR;
				end
			end
			CMD_DOUBLE: begin
				if (a_ok) begin
					r_mag = add_mag;
					r_tag = add_tag;
				end else begin
					r_tag = TAG_ERR;
				end
			end
			CMD_NEG: begin
				if (a_ok) begin
					r_mag = a_mag;
					r_tag = (!a_zero && a_tag == TAG_POS) ? TAG_NEG : TAG_POS;
				end else begin
					r_tag = TAG_ERR;
				end
			end
			CMD_HALVE: begin
				if (a_ok) begin
					// whole LSB drops into the fraction MSB as one half
					r_mag = a_mag >> 1;
					if (a_mag[0])
						r_tag = (a_tag == TAG_POS) ? TAG_UNF_POS : TAG_UNF_NEG;
					else
						r_tag = a_tag;
				end else begin
					r_tag = TAG_ERR;
				end
			end
			CMD_CMP: begin
				if (a_ok && b_ok)
					r_cmp = cmp_v;
				else
					r_tag = TAG_ERR;
			end
			default: begin
				r_tag = TAG_ERR;
			end
		endcase
	end

endmodule
